/* rtl/rwt_pkg.sv */
// rwt_pkg: types and constants of the replay window table
// opcodes, payload structs, controller-to-datapath command and status structs
// no dependencies
package rwt_pkg;

    localparam logic [3:0] OP_STORE    = 4'd0;
    localparam logic [3:0] OP_REMOVE   = 4'd1;
    localparam logic [3:0] OP_CLEAR    = 4'd2;
    localparam logic [3:0] OP_COUNT    = 4'd3;
    localparam logic [3:0] OP_SUSPEND  = 4'd4;
    localparam logic [3:0] OP_COLLECT  = 4'd5;
    localparam logic [3:0] OP_BEGIN    = 4'd6;
    localparam logic [3:0] OP_COMPLETE = 4'd7;
    localparam logic [3:0] OP_ABORT    = 4'd8;
    localparam logic [3:0] OP_DISMISS  = 4'd9;

    localparam logic [1:0] ST_IGNORED  = 2'd0;
    localparam logic [1:0] ST_DONE     = 2'd1;
    localparam logic [1:0] ST_NEW      = 2'd2;
    localparam logic [1:0] ST_REPLACED = 2'd3;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [31:0] session_key;
        logic [15:0] seq_num;
        logic [15:0] data_length;
        logic [15:0] pcm_count;
        logic [7:0]  flag_bits;
        logic        skip_enable;
        logic [7:0]  max_collect;
    } rwt_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  slot_index;
        logic [3:0]  entry_count;
        logic [15:0] out_seq;
        logic [8:0]  out_length;
        logic [15:0] out_pcm;
        logic [7:0]  out_flags;
        logic        skipped_flag;
        logic        last_result;
    } rwt_out_t;

    // controller commands to the datapath
    typedef struct packed {
        logic load;      // capture input beat, clear scan state
        logic scan;      // examine slot at scan index, advance
        logic sort;      // one insertion-sort step
        logic commit;    // apply the operation's state change
        logic emit_load; // load emit pointer
        logic emit_next; // advance emit pointer
    } rwt_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic sort_done;
        logic emit_last;
        logic list_empty;
    } rwt_sts_t;

endpackage

/* rtl/rwt_ctrl.sv */
// rwt_ctrl: operation sequencer of the replay window table
// steps scan, sort, commit and result phases; depends on rwt_pkg
module rwt_ctrl
    import rwt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     is_collect,
    input  logic     out_free,
    output logic     out_push,
    output rwt_cmd_t cmd,
    input  rwt_sts_t sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_SORT = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        out_push   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) state_next = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) state_next = is_collect ? S_SORT : S_DONE;
            end
            S_SORT: begin
                cmd.sort = 1'b1;
                if (sts.sort_done) state_next = S_DONE;
            end
            S_DONE: begin
                cmd.emit_load = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_push      = 1'b1;
                    cmd.emit_next = 1'b1;
                    if (sts.emit_last) begin
                        // state change lands with the last result beat
                        cmd.commit = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_no_push_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !out_push) else $error("push while idle");
    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_SCAN) else $error("accept lost");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.scan, cmd.sort, cmd.commit})) else $error("cmd clash");

endmodule

/* rtl/rwt_dpath.sv */
// rwt_dpath: slot store, scan, sort and result formation
// one slot per scan cycle, one insertion step per sort cycle; depends on rwt_pkg
module rwt_dpath
    import rwt_pkg::*;
#(
    parameter int WINDOW      = 8,
    parameter int PAYLOAD_MAX = 256
)(
    input  logic     aclk,
    input  logic     aresetn,
    input  rwt_in_t  in_beat,
    input  rwt_cmd_t cmd,
    output rwt_sts_t sts,
    output logic     is_collect,
    output rwt_out_t res
);

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);

    logic [WINDOW-1:0] vld_reg;
    logic [31:0] sess_reg [WINDOW];
    logic [15:0] seq_reg  [WINDOW];
    logic [8:0]  len_reg  [WINDOW];
    logic [15:0] pcm_reg  [WINDOW];
    logic [7:0]  flg_reg  [WINDOW];
    logic [IW-1:0] wp_reg;
    logic        pend_reg;
    logic [31:0] psess_reg;
    logic        drain_reg;

    rwt_in_t     op_reg;
    logic [IW-1:0] idx_reg;
    logic        scan_end_reg;
    logic        hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] n_reg;
    logic        skip_reg;
    logic [IW-1:0] list_reg [WINDOW];
    logic [CW-1:0] si_reg, sj_reg;
    logic [IW-1:0] e_reg;
    logic        sort_act_reg;
    logic [CW-1:0] ep_reg;

    logic [CW-1:0] cap;
    logic          same_sess, same_seq, store_ok, col_ok;

    assign is_collect = (op_reg.opcode == OP_COLLECT);
    assign cap = (op_reg.max_collect > 8'(WINDOW)) ? CW'(WINDOW) : CW'(op_reg.max_collect);
    assign same_sess = vld_reg[idx_reg] && sess_reg[idx_reg] == op_reg.session_key;
    assign same_seq  = seq_reg[idx_reg] == op_reg.seq_num;
    assign store_ok = op_reg.session_key != 32'd0 && op_reg.data_length != 16'd0
                   && {16'd0, op_reg.data_length} <= 32'(PAYLOAD_MAX) && !drain_reg;
    assign col_ok = cap != '0 && !drain_reg && pend_reg && psess_reg == op_reg.session_key;

    assign sts.scan_done  = scan_end_reg;
    assign sts.sort_done  = !sort_act_reg || si_reg >= n_reg;
    assign sts.list_empty = n_reg == '0;
    assign sts.emit_last  = !is_collect || !col_ok || n_reg == '0 || ep_reg + 1'b1 >= n_reg;

    // sort step: compare list[j-1] with pending element e
    logic [IW-1:0] prev;
    logic          shift;
    assign prev  = list_reg[IW'(sj_reg - 1'b1)];
    assign shift = sj_reg != '0 && seq_reg[prev] > seq_reg[e_reg];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= in_beat;
        end
        if (cmd.scan) begin
            if (!hit_reg && same_sess && same_seq) begin
                hit_idx_reg <= idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            wp_reg       <= '0;
            pend_reg     <= 1'b0;
            psess_reg    <= '0;
            drain_reg    <= 1'b0;
            idx_reg      <= '0;
            scan_end_reg <= 1'b0;
            hit_reg      <= 1'b0;
            cnt_reg      <= '0;
            n_reg        <= '0;
            skip_reg     <= 1'b0;
            si_reg       <= '0;
            sj_reg       <= '0;
            e_reg        <= '0;
            sort_act_reg <= 1'b0;
            ep_reg       <= '0;
        end else begin
            if (cmd.load) begin
                idx_reg      <= '0;
                scan_end_reg <= 1'b0;
                hit_reg      <= 1'b0;
                cnt_reg      <= '0;
                n_reg        <= '0;
                skip_reg     <= 1'b0;
                sort_act_reg <= 1'b0;
            end
            if (cmd.scan && !scan_end_reg) begin
                if (same_sess && same_seq) hit_reg <= 1'b1;
                if (same_sess) begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (op_reg.skip_enable && same_seq) begin
                        skip_reg <= 1'b1;
                    end else if (n_reg < cap) begin
                        n_reg <= n_reg + 1'b1;
                    end
                end
                if (32'(idx_reg) == WINDOW - 1) begin
                    scan_end_reg <= 1'b1;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (cmd.scan && scan_end_reg) begin
                sort_act_reg <= 1'b1;
                si_reg       <= CW'(1);
                sj_reg       <= CW'(1);
                e_reg        <= list_reg[IW'(1 % WINDOW)];
            end
            if (cmd.sort && sort_act_reg && si_reg < n_reg) begin
                if (shift) begin
                    sj_reg <= sj_reg - 1'b1;
                end else begin
                    si_reg <= si_reg + 1'b1;
                    sj_reg <= si_reg + 1'b1;
                    e_reg  <= list_reg[IW'(si_reg + 1'b1)];
                end
            end
            if (cmd.emit_load) ep_reg <= '0;
            if (cmd.emit_next) ep_reg <= ep_reg + 1'b1;
            if (cmd.commit) begin
                unique case (op_reg.opcode)
                    OP_STORE: begin
                        if (store_ok && !hit_reg) begin
                            vld_reg[wp_reg] <= 1'b1;
                            wp_reg <= (32'(wp_reg) == WINDOW - 1) ? '0 : wp_reg + 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (op_reg.session_key != 32'd0 && hit_reg) begin
                            vld_reg[hit_idx_reg] <= 1'b0;
                        end
                    end
                    OP_CLEAR: begin
                        if (op_reg.session_key != 32'd0) begin
                            for (int i = 0; i < WINDOW; i++) begin
                                if (sess_reg[i] == op_reg.session_key) vld_reg[i] <= 1'b0;
                            end
                            if (pend_reg && psess_reg == op_reg.session_key) begin
                                pend_reg  <= 1'b0;
                                psess_reg <= '0;
                            end
                        end
                    end
                    OP_SUSPEND: begin
                        if (op_reg.session_key != 32'd0 && cnt_reg != '0) begin
                            pend_reg  <= 1'b1;
                            psess_reg <= op_reg.session_key;
                        end
                    end
                    OP_BEGIN: drain_reg <= 1'b1;
                    OP_COMPLETE: begin
                        drain_reg <= 1'b0;
                        pend_reg  <= 1'b0;
                        psess_reg <= '0;
                    end
                    OP_ABORT: drain_reg <= 1'b0;
                    OP_DISMISS: begin
                        pend_reg  <= 1'b0;
                        psess_reg <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // slot payload and collect list (no reset; gated by valid bits)
    always_ff @(posedge aclk) begin
        if (cmd.scan && !scan_end_reg && same_sess && !(op_reg.skip_enable && same_seq)
                && n_reg < cap) begin
            list_reg[IW'(n_reg)] <= idx_reg;
        end
        if (cmd.sort && sort_act_reg && si_reg < n_reg) begin
            if (shift) begin
                list_reg[IW'(sj_reg)] <= prev;
            end else begin
                list_reg[IW'(sj_reg)] <= e_reg;
            end
        end
        if (cmd.commit && op_reg.opcode == OP_STORE && store_ok) begin
            if (hit_reg) begin
                len_reg[hit_idx_reg] <= op_reg.data_length[8:0];
                pcm_reg[hit_idx_reg] <= op_reg.pcm_count;
                flg_reg[hit_idx_reg] <= op_reg.flag_bits;
            end else begin
                sess_reg[wp_reg] <= op_reg.session_key;
                seq_reg[wp_reg]  <= op_reg.seq_num;
                len_reg[wp_reg]  <= op_reg.data_length[8:0];
                pcm_reg[wp_reg]  <= op_reg.pcm_count;
                flg_reg[wp_reg]  <= op_reg.flag_bits;
            end
        end
    end

    logic [IW-1:0] es;
    assign es = list_reg[IW'(ep_reg)];

    always_comb begin
        res = '0;
        res.last_result = sts.emit_last;
        unique case (op_reg.opcode)
            OP_STORE: begin
                if (store_ok) begin
                    res.status     = hit_reg ? ST_REPLACED : ST_NEW;
                    res.slot_index = 3'(hit_reg ? hit_idx_reg : wp_reg);
                end
            end
            OP_REMOVE: begin
                if (op_reg.session_key != 32'd0 && hit_reg) begin
                    res.status     = ST_DONE;
                    res.slot_index = 3'(hit_idx_reg);
                end
            end
            OP_CLEAR: res.status = (op_reg.session_key != 32'd0) ? ST_DONE : ST_IGNORED;
            OP_COUNT: begin
                res.status      = ST_DONE;
                res.entry_count = 4'(cnt_reg);
            end
            OP_SUSPEND: res.status = (op_reg.session_key != 32'd0 && cnt_reg != '0)
                                     ? ST_DONE : ST_IGNORED;
            OP_COLLECT: begin
                if (col_ok) begin
                    res.skipped_flag = skip_reg;
                    if (n_reg != '0) begin
                        res.status      = ST_DONE;
                        res.slot_index  = 3'(es);
                        res.entry_count = 4'(n_reg);
                        res.out_seq     = seq_reg[es];
                        res.out_length  = len_reg[es];
                        res.out_pcm     = pcm_reg[es];
                        res.out_flags   = flg_reg[es];
                    end
                end
            end
            OP_BEGIN, OP_COMPLETE, OP_ABORT, OP_DISMISS: res.status = ST_DONE;
            default: ;
        endcase
    end

    a_wp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(wp_reg) < WINDOW) else $error("write pointer out of range");
    a_n_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= cnt_reg) else $error("collected more than matched");

endmodule

/* rtl/replay_window_table.sv */
// replay_window_table: top level of the replay window table
// output register plus rwt_ctrl and rwt_dpath; depends on rwt_pkg
//
// One operation per input beat on s_ (valid/ready), results on m_ (valid/ready).
// Every operation yields one result beat; collect yields one beat per collected
// slot in ascending sequence order, last_result marking the final one.
// An accepted beat scans the WINDOW slots one per cycle; collect then runs an
// insertion sort one compare per cycle, then passes an emit setup state (S_DONE);
// results then leave at one per cycle through the output register while the
// receiver takes them, and the state change lands with the last result.
// The next beat is taken once the last result is registered.
// s_ready is high only while the block is idle.
// A stalled receiver holds m_ payload steady; the block waits and loses nothing.
// Synchronous reset empties all slots, clears the pending mark, drain state
// and write pointer; no clearing pass is needed.
module replay_window_table
    import rwt_pkg::*;
#(
    parameter int WINDOW      = 8,
    parameter int PAYLOAD_MAX = 256
)(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rwt_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rwt_out_t m_data
);

    rwt_cmd_t cmd;
    rwt_sts_t sts;
    rwt_out_t res;
    logic     is_collect, out_push, out_free;
    logic     mv_reg;
    rwt_out_t md_reg;

    assign out_free = !mv_reg || m_ready;
    assign m_valid  = mv_reg;
    assign m_data   = md_reg;

    rwt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .is_collect(is_collect), .out_free(out_free), .out_push(out_push),
        .cmd(cmd), .sts(sts)
    );

    rwt_dpath #(.WINDOW(WINDOW), .PAYLOAD_MAX(PAYLOAD_MAX)) u_dpath (
        .aclk(aclk), .aresetn(aresetn), .in_beat(s_data), .cmd(cmd), .sts(sts),
        .is_collect(is_collect), .res(res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (out_push) begin
            mv_reg <= 1'b1;
        end else if (m_ready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_push) md_reg <= res;
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("beat dropped");

endmodule

/* bench/rwt_checker.sv */
// rwt_checker: watches both channels of replay_window_table, predicts results, compares
// keeps its own copy of the slot table; depends on rwt_pkg
module rwt_checker
    import rwt_pkg::*;
#(
    parameter int WINDOW      = 8,
    parameter int PAYLOAD_MAX = 256
)(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  rwt_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  rwt_out_t m_data,
    output int       fail_count,
    output int       pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        tbl_valid [WINDOW];
    logic [31:0] tbl_sess  [WINDOW];
    logic [15:0] tbl_seq   [WINDOW];
    logic [8:0]  tbl_len   [WINDOW];
    logic [15:0] tbl_pcm   [WINDOW];
    logic [7:0]  tbl_flags [WINDOW];
    int          wr_ptr;
    logic        mark;
    logic [31:0] mark_sess;
    logic        draining;

    rwt_out_t expected_beats[$];

    assign pending_results = expected_beats.size();

    function automatic rwt_out_t simple_beat(logic [1:0] st, int slot, int cnt);
        rwt_out_t r;
        r = '0;
        r.status = st;
        r.slot_index = slot[2:0];
        r.entry_count = cnt[3:0];
        r.last_result = 1'b1;
        return r;
    endfunction

    function automatic void wipe(int i);
        tbl_valid[i] = 0;
        tbl_sess[i] = 0;
        tbl_seq[i] = 0;
        tbl_len[i] = 0;
        tbl_pcm[i] = 0;
        tbl_flags[i] = 0;
    endfunction

    function automatic int session_count(logic [31:0] s);
        int n;
        n = 0;
        for (int i = 0; i < WINDOW; i++)
            if (tbl_valid[i] && tbl_sess[i] == s) n++;
        return n;
    endfunction

    function automatic void predict_op(rwt_in_t b);
        int list[$];
        int cap, hit, e, j;
        bit skipped;
        rwt_out_t r;
        hit = -1;
        case (b.opcode)
            OP_STORE: begin
                if (b.session_key == 0 || b.data_length == 0 ||
                    b.data_length > PAYLOAD_MAX || draining) begin
                    expected_beats.push_back(simple_beat(ST_IGNORED, 0, 0));
                end else begin
                    for (int i = 0; i < WINDOW && hit < 0; i++)
                        if (tbl_valid[i] && tbl_sess[i] == b.session_key &&
                            tbl_seq[i] == b.seq_num) hit = i;
                    if (hit >= 0) begin
                        tbl_len[hit] = b.data_length[8:0];
                        tbl_pcm[hit] = b.pcm_count;
                        tbl_flags[hit] = b.flag_bits;
                        expected_beats.push_back(simple_beat(ST_REPLACED, hit, 0));
                    end else begin
                        hit = wr_ptr;
                        tbl_valid[hit] = 1;
                        tbl_sess[hit] = b.session_key;
                        tbl_seq[hit] = b.seq_num;
                        tbl_len[hit] = b.data_length[8:0];
                        tbl_pcm[hit] = b.pcm_count;
                        tbl_flags[hit] = b.flag_bits;
                        wr_ptr = (wr_ptr + 1) % WINDOW;
                        expected_beats.push_back(simple_beat(ST_NEW, hit, 0));
                    end
                end
            end
            OP_REMOVE: begin
                if (b.session_key != 0)
                    for (int i = 0; i < WINDOW && hit < 0; i++)
                        if (tbl_valid[i] && tbl_sess[i] == b.session_key &&
                            tbl_seq[i] == b.seq_num) hit = i;
                if (hit >= 0) begin
                    wipe(hit);
                    expected_beats.push_back(simple_beat(ST_DONE, hit, 0));
                end else begin
                    expected_beats.push_back(simple_beat(ST_IGNORED, 0, 0));
                end
            end
            OP_CLEAR: begin
                if (b.session_key == 0) begin
                    expected_beats.push_back(simple_beat(ST_IGNORED, 0, 0));
                end else begin
                    for (int i = 0; i < WINDOW; i++)
                        if (tbl_valid[i] && tbl_sess[i] == b.session_key) wipe(i);
                    if (mark && mark_sess == b.session_key) begin
                        mark = 0;
                        mark_sess = 0;
                    end
                    expected_beats.push_back(simple_beat(ST_DONE, 0, 0));
                end
            end
            OP_COUNT:
                expected_beats.push_back(simple_beat(ST_DONE, 0,
                                                     session_count(b.session_key)));
            OP_SUSPEND: begin
                if (b.session_key == 0 || session_count(b.session_key) == 0) begin
                    expected_beats.push_back(simple_beat(ST_IGNORED, 0, 0));
                end else begin
                    mark = 1;
                    mark_sess = b.session_key;
                    expected_beats.push_back(simple_beat(ST_DONE, 0, 0));
                end
            end
            OP_COLLECT: begin
                cap = (b.max_collect > WINDOW) ? WINDOW : b.max_collect;
                skipped = 0;
                if (cap == 0 || draining || !mark || mark_sess != b.session_key) begin
                    expected_beats.push_back(simple_beat(ST_IGNORED, 0, 0));
                end else begin
                    for (int i = 0; i < WINDOW; i++) begin
                        if (tbl_valid[i] && tbl_sess[i] == b.session_key) begin
                            if (b.skip_enable && tbl_seq[i] == b.seq_num) skipped = 1;
                            else if (list.size() < cap) list.push_back(i);
                        end
                    end
                    for (int i = 1; i < list.size(); i++) begin
                        e = list[i];
                        j = i;
                        while (j > 0 && tbl_seq[list[j-1]] > tbl_seq[e]) begin
                            list[j] = list[j-1];
                            j--;
                        end
                        list[j] = e;
                    end
                    if (list.size() == 0) begin
                        r = simple_beat(ST_IGNORED, 0, 0);
                        r.skipped_flag = skipped;
                        expected_beats.push_back(r);
                    end
                    for (int k = 0; k < list.size(); k++) begin
                        r = simple_beat(ST_DONE, list[k], list.size());
                        r.out_seq = tbl_seq[list[k]];
                        r.out_length = tbl_len[list[k]];
                        r.out_pcm = tbl_pcm[list[k]];
                        r.out_flags = tbl_flags[list[k]];
                        r.skipped_flag = skipped;
                        r.last_result = (k == list.size() - 1);
                        expected_beats.push_back(r);
                    end
                end
            end
            OP_BEGIN: begin
                draining = 1;
                expected_beats.push_back(simple_beat(ST_DONE, 0, 0));
            end
            OP_COMPLETE: begin
                draining = 0;
                mark = 0;
                mark_sess = 0;
                expected_beats.push_back(simple_beat(ST_DONE, 0, 0));
            end
            OP_ABORT: begin
                draining = 0;
                expected_beats.push_back(simple_beat(ST_DONE, 0, 0));
            end
            OP_DISMISS: begin
                mark = 0;
                mark_sess = 0;
                expected_beats.push_back(simple_beat(ST_DONE, 0, 0));
            end
            default:
                expected_beats.push_back(simple_beat(ST_IGNORED, 0, 0));
        endcase
    endfunction

    always @(posedge aclk) begin
        rwt_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) wipe(i);
            wr_ptr = 0;
            mark = 0;
            mark_sess = 0;
            draining = 0;
            fail_count <= 0;
            expected_beats.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result beat %p", m_data);
                end else begin
                    want = expected_beats.pop_front();
                    if (m_data !== want) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected %p actual %p", want, m_data);
                    end
                end
            end
            if (s_valid && s_ready) predict_op(s_data);
        end
    end
endmodule

/* bench/tb_top.sv */
// tb_top: stimulus and verdict for replay_window_table
// drives operation beats and result backpressure; depends on rwt_pkg, rwt_checker and replay_window_table
module tb_top;
    import rwt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW = 8;
    localparam int LIMIT  = 400000;

    logic     aclk = 0;
    logic     aresetn = 0;
    logic     s_valid = 0;
    logic     s_ready;
    rwt_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 0;
    rwt_out_t m_data;
    int       fail_count;
    int       pending_results;
    int       cycles = 0;
    bit       calm = 0;

    logic [31:0] sess_pool[4] = '{32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5A5A_A5A5};

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    replay_window_table dut (.*);

    rwt_checker chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int gap;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 0;
                gap = $urandom_range(1, 15);
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
        end
    end

    task automatic send_beat(rwt_in_t b);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic rwt_in_t make_op(logic [3:0] op, logic [31:0] s, logic [15:0] q,
                                        logic [15:0] len, logic [7:0] cap, logic sk);
        rwt_in_t b;
        b.opcode = op;
        b.session_key = s;
        b.seq_num = q;
        b.data_length = len;
        b.pcm_count = 16'($urandom);
        b.flag_bits = 8'($urandom);
        b.skip_enable = sk;
        b.max_collect = cap;
        return b;
    endfunction

    function automatic rwt_in_t random_op();
        rwt_in_t b;
        int pick;
        logic [15:0] len;
        pick = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 256));
        b = make_op(OP_STORE, sess_pool[$urandom_range(0, 3)], 16'($urandom_range(0, 5)),
                    len, 8'($urandom_range(0, 10)), 1'($urandom));
        if ($urandom_range(0, 15) == 0) b.seq_num = 16'($urandom);
        if ($urandom_range(0, 15) == 0) b.max_collect = 8'($urandom);
        if ($urandom_range(0, 20) == 0) b.session_key = 32'd0;
        if ($urandom_range(0, 20) == 0) b.session_key = 32'($urandom);
        if (pick < 40) b.opcode = OP_STORE;
        else if (pick < 48) b.opcode = OP_REMOVE;
        else if (pick < 51) b.opcode = OP_CLEAR;
        else if (pick < 57) b.opcode = OP_COUNT;
        else if (pick < 67) b.opcode = OP_SUSPEND;
        else if (pick < 85) b.opcode = OP_COLLECT;
        else if (pick < 88) b.opcode = OP_BEGIN;
        else if (pick < 92) b.opcode = OP_COMPLETE;
        else if (pick < 95) b.opcode = OP_ABORT;
        else if (pick < 98) b.opcode = OP_DISMISS;
        else b.opcode = 4'($urandom_range(10, 15));
        return b;
    endfunction

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_beat(make_op(OP_COUNT, 0, 0, 0, 0, 0));
        send_beat(make_op(OP_STORE, 0, 1, 10, 0, 0));
        send_beat(make_op(OP_STORE, 7, 1, 0, 0, 0));
        send_beat(make_op(OP_STORE, 7, 1, 257, 0, 0));
        send_beat(make_op(OP_STORE, 7, 1, 16'hFFFF, 0, 0));
        send_beat(make_op(OP_STORE, 32'hFFFF_FFFF, 16'hFFFF, 256, 0, 0));
        send_beat(make_op(OP_STORE, 7, 5, 1, 0, 0));
        send_beat(make_op(OP_STORE, 7, 3, 100, 0, 0));
        send_beat(make_op(OP_STORE, 7, 5, 200, 0, 0));
        send_beat(make_op(OP_STORE, 7, 3, 50, 0, 0));
        send_beat(make_op(OP_COUNT, 7, 0, 0, 0, 0));
        send_beat(make_op(OP_COLLECT, 7, 0, 0, 8, 0));
        send_beat(make_op(OP_SUSPEND, 9, 0, 0, 0, 0));
        send_beat(make_op(OP_SUSPEND, 7, 0, 0, 0, 0));
        send_beat(make_op(OP_COLLECT, 7, 5, 0, 8'hFF, 1));
        send_beat(make_op(OP_COLLECT, 7, 3, 0, 1, 1));
        send_beat(make_op(OP_COLLECT, 7, 0, 0, 0, 0));
        send_beat(make_op(OP_BEGIN, 0, 0, 0, 0, 0));
        send_beat(make_op(OP_COLLECT, 7, 0, 0, 8, 0));
        send_beat(make_op(OP_STORE, 7, 9, 9, 0, 0));
        send_beat(make_op(OP_ABORT, 0, 0, 0, 0, 0));
        send_beat(make_op(OP_REMOVE, 7, 5, 0, 0, 0));
        send_beat(make_op(OP_REMOVE, 7, 5, 0, 0, 0));
        send_beat(make_op(OP_CLEAR, 7, 0, 0, 0, 0));
        send_beat(make_op(4'd15, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1));
        send_beat(make_op(OP_DISMISS, 0, 0, 0, 0, 0));
        send_beat(make_op(OP_COMPLETE, 0, 0, 0, 0, 0));
        for (int n = 0; n < 310; n++) begin
            if (n == 260) calm = 1;
            send_beat(random_op());
        end
        s_valid <= 0;
        while (pending_results != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
